/* sv/sed_pkg.sv */
// ----------------------------------------------------------------------------
// sed_pkg
// Shared constants and types for the skeleton endpoint detector.
// ----------------------------------------------------------------------------
package sed_pkg;

  // default line store depth
  localparam int MAX_WIDTH_DEF = 1024;

  // configuration register widths and limits
  localparam int IMG_W_BITS   = 11;
  localparam int IMG_H_BITS   = 13;
  localparam int ROW_BITS     = 12;
  localparam int HEIGHT_LIMIT = 4096;
  localparam int PIX_BITS     = 8;
  localparam int CFG_DW       = 32;
  localparam int CFG_AW       = 3;

  // result fields in tdata besides the column: endpoint flag and row
  localparam int RES_FIXED_BITS = 1 + ROW_BITS;

  // register indexes (paddr[2])
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  // per-item flags travelling down the pipeline with the centre position
  typedef struct packed {
    logic result_valid;
    logic judge_en;
    logic frame_done;
  } sed_flags_t;

endpackage

/* sv/sed_line_cell.sv */
// ----------------------------------------------------------------------------
// sed_line_cell
// One line store cell: keeps one image row of set bits, hands the bit it
// held at the current column on to the next cell through its read register.
// ----------------------------------------------------------------------------
module sed_line_cell #(
  parameter int MAX_WIDTH = sed_pkg::MAX_WIDTH_DEF,
  localparam int AW = $clog2(MAX_WIDTH)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step_i,
  input  logic          vld_i,
  input  logic [AW-1:0] addr_i,
  input  logic          bit_i,
  output logic          vld_o,
  output logic [AW-1:0] addr_o,
  output logic          bit_o
);
  import sed_pkg::*;

  localparam logic [AW:0] FILL_MAX = (AW + 1)'(MAX_WIDTH);

  logic          mem [MAX_WIDTH];
  logic          rd_r;
  logic          rd_ok_r;
  logic          vld_r;
  logic [AW-1:0] addr_r;
  logic [AW:0]   fill_r;
  logic          take;

  assign take = step_i && vld_i;

  // line store: old bit read out, new bit written at the same column
  always_ff @(posedge clk) begin
    if (take) begin
      rd_r           <= mem[addr_i];
      mem[addr_i]    <= bit_i;
      rd_ok_r        <= ({1'b0, addr_i} < fill_r);
      addr_r         <= addr_i;
    end
  end

  // columns written since reset always form a prefix, so a count marks them
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= 1'b0;
      fill_r <= '0;
    end else if (step_i) begin
      vld_r <= vld_i;
      if (vld_i && fill_r != FILL_MAX && addr_i == fill_r[AW-1:0]) begin
        fill_r <= fill_r + 1'b1;
      end
    end
  end

  // unwritten entries read as cleared
  assign bit_o  = rd_r & rd_ok_r;
  assign vld_o  = vld_r;
  assign addr_o = addr_r;

  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_MAX)
    else $error("line cell fill count beyond depth");

  a_write_in_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    take |-> ({1'b0, addr_i} <= fill_r))
    else $error("line cell write skips past written prefix");

  a_fill_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r |=> fill_r >= $past(fill_r))
    else $error("line cell fill count went backwards");

endmodule

/* sv/sed_window.sv */
// ----------------------------------------------------------------------------
// sed_window
// 3x3 window, endpoint test and output register. Aligns the pixel, the
// middle-row bit and the top-row bit that arrive from the line cells.
// ----------------------------------------------------------------------------
module sed_window #(
  parameter int MAX_WIDTH = sed_pkg::MAX_WIDTH_DEF,
  localparam int CW = $clog2(MAX_WIDTH)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           step_i,
  input  logic                           pix_i,
  input  sed_pkg::sed_flags_t            flags_i,
  input  logic [CW-1:0]                  ccol_i,
  input  logic [sed_pkg::ROW_BITS-1:0]   crow_i,
  input  logic                           mid_i,
  input  logic                           top_i,
  input  logic                           s2_vld_i,
  output logic                           out_valid_o,
  output logic                           result_valid_o,
  output logic                           is_endpoint_o,
  output logic [CW-1:0]                  center_column_o,
  output logic [sed_pkg::ROW_BITS-1:0]   center_row_o,
  output logic                           frame_done_o
);
  import sed_pkg::*;

  logic                pix_s1_r, pix_s2_r, mid_s2_r;
  sed_flags_t          flags_s1_r, flags_s2_r;
  logic [CW-1:0]       ccol_s1_r, ccol_s2_r;
  logic [ROW_BITS-1:0] crow_s1_r, crow_s2_r;
  logic [8:0]          win_r, win_nxt;
  logic                judge_nxt;
  logic                out_valid_r, rv_r, ep_r, done_r;
  logic [CW-1:0]       ccol_r;
  logic [ROW_BITS-1:0] crow_r;

  // endpoint test; bit 3*k+j is window row k, column j
  function automatic logic judge(input logic [8:0] w);
    logic [3:0] n;
    logic       a, b, c, d;
    logic       res;
    n = '0;
    for (int i = 0; i < 9; i++) begin
      n = n + {3'b000, w[i]};
    end
    res = 1'b0;
    if (w[4]) begin
      priority case (n)
        4'd2: res = 1'b1;
        4'd3: begin
          a   = w[1] && (w[0] || w[2]);
          b   = w[5] && (w[2] || w[8]);
          c   = w[7] && (w[6] || w[8]);
          d   = w[3] && (w[0] || w[6]);
          res = a || b || c || d;
        end
        4'd4: begin
          a   = w[1] && w[0] && w[2];
          b   = w[5] && w[2] && w[8];
          c   = w[7] && w[6] && w[8];
          d   = w[3] && w[0] && w[6];
          res = a || b || c || d;
        end
        default: res = 1'b0;
      endcase
    end
    return res;
  endfunction

  // delay the pixel and per-item tag until the top-row bit is out
  always_ff @(posedge clk) begin
    if (step_i) begin
      pix_s1_r   <= pix_i;
      flags_s1_r <= flags_i;
      ccol_s1_r  <= ccol_i;
      crow_s1_r  <= crow_i;
      pix_s2_r   <= pix_s1_r;
      mid_s2_r   <= mid_i;
      flags_s2_r <= flags_s1_r;
      ccol_s2_r  <= ccol_s1_r;
      crow_s2_r  <= crow_s1_r;
    end
  end

  // shift each window row left and bring in the new column
  always_comb begin
    win_nxt   = {pix_s2_r, win_r[8:7], mid_s2_r, win_r[5:4], top_i, win_r[2:1]};
    judge_nxt = flags_s2_r.judge_en && judge(win_nxt);
  end

  // window and output payload
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (step_i && s2_vld_i) begin
      win_r <= win_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step_i && s2_vld_i) begin
      rv_r   <= flags_s2_r.result_valid;
      ep_r   <= judge_nxt;
      done_r <= flags_s2_r.frame_done;
      ccol_r <= ccol_s2_r;
      crow_r <= crow_s2_r;
    end
  end

  // output item valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step_i) begin
      out_valid_r <= s2_vld_i;
    end
  end

  assign out_valid_o     = out_valid_r;
  assign result_valid_o  = rv_r;
  assign is_endpoint_o   = ep_r;
  assign center_column_o = ccol_r;
  assign center_row_o    = crow_r;
  assign frame_done_o    = done_r;

  a_ep_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && ep_r |-> rv_r)
    else $error("endpoint flagged without a judged centre");

  a_unjudged_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !rv_r |-> !ep_r && ccol_r == '0 && crow_r == '0)
    else $error("unjudged item carries nonzero fields");

  a_ep_centre_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && ep_r |-> win_r[4])
    else $error("endpoint flagged on a clear centre");

endmodule

/* sv/skeleton_endpoint_detector.sv */
// ----------------------------------------------------------------------------
// skeleton_endpoint_detector
// Marks endpoints of a thinned binary image streamed one pixel per item.
// ----------------------------------------------------------------------------
// Takes one pixel per cycle in raster order while the output is not
// stalled and returns one item per pixel, judging the pixel one row up and
// one column left; a result is registered in turn by the reads of the two
// line store cells in the chain and by the output register, and the block
// sustains one item per clock. Stalls on the output stop the whole
// pipeline. The line stores are not swept after reset: each cell counts the
// columns written so far and reads unwritten ones as clear, so items are
// taken right after reset.
// in_tuser marks the first pixel of an image; out_tlast marks the item of its
// last pixel, out_tuser says whether the item carries a centre.
module skeleton_endpoint_detector #(
  parameter int MAX_WIDTH = sed_pkg::MAX_WIDTH_DEF,
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int OUT_DW = ((sed_pkg::RES_FIXED_BITS + CW + 7) / 8) * 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // input item
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [sed_pkg::PIX_BITS-1:0] in_tdata,   // [7:0] pixel_value
  input  logic                         in_tuser,   // [0] frame_start
  // result item
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [OUT_DW-1:0]            out_tdata,  // is_endpoint, center_column, center_row
  output logic                         out_tuser,  // [0] result_valid
  output logic                         out_tlast,  // frame_done
  // configuration
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [sed_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [sed_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [sed_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                         cfg_pready
);
  import sed_pkg::*;

  localparam int EW = (CW + 1 > IMG_W_BITS) ? CW + 1 : IMG_W_BITS;

  logic [IMG_W_BITS-1:0] width_r;
  logic [IMG_H_BITS-1:0] height_r;
  logic [EW-1:0]         w_ext, w_eff;
  logic [IMG_H_BITS-1:0] h_eff;
  logic                  cfg_wr;

  logic [CW-1:0]         col_r, col_nxt, col_a, col_b, ccol;
  logic [ROW_BITS-1:0]   row_r, row_nxt, row_a, row_c, crow;
  logic [IMG_H_BITS-1:0] row_b, row_inc;
  logic [EW-1:0]         col_inc;
  logic                  wrap_a, last_col, last_row;
  sed_flags_t            flags;
  logic                  step, acc, pix;

  logic                  c0_vld, c1_vld;
  logic [CW-1:0]         c0_addr, c1_addr;
  logic                  mid_bit, top_bit;

  logic                  rv_o, ep_o, done_o;
  logic [CW-1:0]         ccol_o;
  logic [ROW_BITS-1:0]   crow_o;

  // configuration registers
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= IMG_W_BITS'(64);
      height_r <= IMG_H_BITS'(64);
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_IMAGE_WIDTH:  width_r  <= cfg_pwdata[IMG_W_BITS-1:0];
        REG_IMAGE_HEIGHT: height_r <= cfg_pwdata[IMG_H_BITS-1:0];
        default:          width_r  <= width_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_IMAGE_WIDTH:  cfg_prdata = CFG_DW'(width_r);
      REG_IMAGE_HEIGHT: cfg_prdata = CFG_DW'(height_r);
      default:          cfg_prdata = '0;
    endcase
  end

  // effective image size, saturated
  always_comb begin
    w_ext = EW'(width_r);
    if (width_r == '0) w_eff = EW'(1);
    else if (w_ext > EW'(MAX_WIDTH)) w_eff = EW'(MAX_WIDTH);
    else w_eff = w_ext;
    if (height_r == '0) h_eff = IMG_H_BITS'(1);
    else if (height_r > IMG_H_BITS'(HEIGHT_LIMIT)) h_eff = IMG_H_BITS'(HEIGHT_LIMIT);
    else h_eff = height_r;
  end

  // handshake: the pipeline moves whenever the output register is empty or its item is taken
  assign step      = !out_tvalid || out_tready;
  assign in_tready = step;
  assign acc       = in_tvalid && step;
  assign pix       = (in_tdata != '0);

  // position of the arriving pixel and of the next one
  always_comb begin
    col_a    = in_tuser ? '0 : col_r;
    row_a    = in_tuser ? '0 : row_r;
    wrap_a   = (EW'(col_a) >= w_eff);
    col_b    = wrap_a ? '0 : col_a;
    row_b    = IMG_H_BITS'(row_a) + IMG_H_BITS'(wrap_a);
    row_c    = (row_b >= h_eff) ? '0 : row_b[ROW_BITS-1:0];
    col_inc  = EW'(col_b) + 1'b1;
    row_inc  = IMG_H_BITS'(row_c) + 1'b1;
    last_col = (col_inc >= w_eff);
    last_row = (row_inc >= h_eff);
    col_nxt  = last_col ? '0 : col_inc[CW-1:0];
    row_nxt  = last_col ? (last_row ? '0 : row_inc[ROW_BITS-1:0]) : row_c;

    // the centre sits left of and above the pixel, so it is never on the
    // right column or the bottom row; only the left and top borders are cut
    flags.result_valid = (col_b != '0) && (row_c != '0);
    flags.judge_en     = (col_b >= CW'(2)) && (row_c >= ROW_BITS'(2));
    flags.frame_done   = (col_inc == w_eff) && (row_inc == h_eff);
    ccol = flags.result_valid ? col_b - 1'b1 : '0;
    crow = flags.result_valid ? row_c - 1'b1 : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // middle row store: pixel in, previous row's bit out
  sed_line_cell #(.MAX_WIDTH(MAX_WIDTH)) u_cell_mid (
    .clk    (clk),
    .rst_n  (rst_n),
    .step_i (step),
    .vld_i  (acc),
    .addr_i (col_b),
    .bit_i  (pix),
    .vld_o  (c0_vld),
    .addr_o (c0_addr),
    .bit_o  (mid_bit)
  );

  // upper row store: middle bit in, row before that out
  sed_line_cell #(.MAX_WIDTH(MAX_WIDTH)) u_cell_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .step_i (step),
    .vld_i  (c0_vld),
    .addr_i (c0_addr),
    .bit_i  (mid_bit),
    .vld_o  (c1_vld),
    .addr_o (c1_addr),
    .bit_o  (top_bit)
  );

  sed_window #(.MAX_WIDTH(MAX_WIDTH)) u_window (
    .clk             (clk),
    .rst_n           (rst_n),
    .step_i          (step),
    .pix_i           (pix),
    .flags_i         (flags),
    .ccol_i          (ccol),
    .crow_i          (crow),
    .mid_i           (mid_bit),
    .top_i           (top_bit),
    .s2_vld_i        (c1_vld && (c1_addr == c1_addr)),
    .out_valid_o     (out_tvalid),
    .result_valid_o  (rv_o),
    .is_endpoint_o   (ep_o),
    .center_column_o (ccol_o),
    .center_row_o    (crow_o),
    .frame_done_o    (done_o)
  );

  // result packing
  assign out_tdata = OUT_DW'({crow_o, ccol_o, ep_o});
  assign out_tuser = rv_o;
  assign out_tlast = done_o;

  a_frame_start_restart: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_tuser && w_eff > EW'(1) |=> col_r == CW'(1) && row_r == '0)
    else $error("frame start did not restart the position counters");

  a_last_pixel_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    acc && flags.frame_done |=> col_r == '0 && row_r == '0)
    else $error("counters did not wrap after the last pixel");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result item valid straight after reset");

endmodule
